@@ rtl/core/kvi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe vector interpolator package
// Shared constants, payload words, controller states and command/status types.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int KVI_MAX_KEYS = 64;
  localparam int COUNT_W      = 7;
  localparam int FRAC_BITS    = 16;
  localparam int DIV_STEPS    = FRAC_BITS;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        query_time;
  } kvi_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_interval;
  } kvi_out_t;

  // One table entry as it sits in the key memory
  typedef struct packed {
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
  } kvi_key_t;

  localparam int KEY_W = $bits(kvi_key_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_CMP_HI,
    ST_RD_LO,
    ST_CAP_LO,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } kvi_state_e;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_Z
  } kvi_comp_e;

  typedef struct packed {
    logic      load_we;
    logic      cap_query;
    logic      cap_hi;
    logic      cap_lo;
    logic      div_init;
    logic      single;
    logic      div_step;
    logic      mul_go;
    logic      acc_go;
    logic      out_load;
    kvi_comp_e comp;
  } kvi_cmd_t;

  typedef struct packed {
    logic q_lt_t;
  } kvi_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/kvi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/kvi_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe interpolator datapath
// Key memory, query compare, restoring divider for the blend factor and a
// shared multiplier for the three component mixes.
// ----------------------------------------------------------------------------
module kvi_dpath
  import kvi_pkg::*;
#(
  parameter int MAX_KEYS = KVI_MAX_KEYS
) (
  input  wire logic                        clk_i,
  input  wire kvi_cmd_t                    cmd_i,
  output kvi_sts_t                         sts_o,
  input  wire logic [$clog2(MAX_KEYS)-1:0] rd_addr_i,
  input  wire kvi_in_t                     in_data_i,
  output kvi_out_t                         out_data_o
);

  localparam int IW     = $clog2(MAX_KEYS);
  localparam int F_W    = FRAC_BITS + 1;
  localparam int PROD_W = 33 + F_W + 1;
  localparam logic signed [PROD_W-1:0] RoundHalf = PROD_W'(1) << (FRAC_BITS - 1);

  // Key memory
  logic [31:0]    idx_ext;
  logic           ram_we;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;
  kvi_key_t       rd_key;

  assign idx_ext   = 32'(in_data_i.key_index);
  assign ram_we    = cmd_i.load_we && (idx_ext < 32'(MAX_KEYS));
  assign ram_wdata = {in_data_i.key_time, in_data_i.key_x, in_data_i.key_y, in_data_i.key_z};
  assign rd_key    = kvi_key_t'(ram_rdata);

  kvi_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_ext[IW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr_i),
    .rdata_o(ram_rdata)
  );

  logic [31:0] query_q;
  kvi_key_t    lo_key_q;
  kvi_key_t    hi_key_q;

  assign sts_o.q_lt_t = query_q < rd_key.key_time;

  // Blend factor set-up
  logic [32:0] num;
  logic [32:0] den;
  logic [32:0] an;
  logic [32:0] ad;
  logic        same_sign;
  logic        eq_time;
  logic        clamp;

  assign num       = {1'b0, query_q} - {1'b0, lo_key_q.key_time};
  assign den       = {1'b0, hi_key_q.key_time} - {1'b0, lo_key_q.key_time};
  assign an        = num[32] ? (~num + 33'd1) : num;
  assign ad        = den[32] ? (~den + 33'd1) : den;
  assign same_sign = num[32] == den[32];
  assign eq_time   = hi_key_q.key_time == lo_key_q.key_time;
  assign clamp     = an >= ad;

  logic                 flag_q;
  logic                 triv_q;
  logic                 one_q;
  logic [31:0]          rem_q;
  logic [31:0]          ad_q;
  logic [FRAC_BITS-1:0] quo_q;

  // Restoring divide, one quotient bit a step
  logic [32:0] r2;
  logic        ge;
  logic [32:0] r2_sub;

  assign r2     = {rem_q, 1'b0};
  assign ge     = r2 >= {1'b0, ad_q};
  assign r2_sub = r2 - {1'b0, ad_q};

  logic [F_W-1:0] f;
  assign f = triv_q ? {one_q, {FRAC_BITS{1'b0}}} : {1'b0, quo_q};

  // Component mix
  logic signed [31:0]       a_sel;
  logic signed [31:0]       b_sel;
  logic signed [32:0]       diff;
  logic signed [PROD_W-1:0] diff_w;
  logic signed [PROD_W-1:0] f_w;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] sum;
  logic signed [PROD_W-1:0] shifted;
  logic signed [31:0]       res;
  logic signed [31:0]       res_x_q;
  logic signed [31:0]       res_y_q;
  logic signed [31:0]       res_z_q;
  kvi_out_t                 out_q;

  always_comb begin
    case (cmd_i.comp)
      COMP_X: begin
        a_sel = lo_key_q.key_x;
        b_sel = hi_key_q.key_x;
      end
      COMP_Y: begin
        a_sel = lo_key_q.key_y;
        b_sel = hi_key_q.key_y;
      end
      COMP_Z: begin
        a_sel = lo_key_q.key_z;
        b_sel = hi_key_q.key_z;
      end
      default: begin
        a_sel = lo_key_q.key_x;
        b_sel = hi_key_q.key_x;
      end
    endcase
  end

  assign diff    = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
  // widen both operands so the full product survives
  assign diff_w  = $signed({{(PROD_W-33){diff[32]}}, diff});
  assign f_w     = $signed({{(PROD_W-F_W){1'b0}}, f});
  assign prod_d  = diff_w * f_w;
  assign sum     = prod_q + RoundHalf;
  assign shifted = sum >>> FRAC_BITS;
  assign res     = a_sel + shifted[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_query) begin
      query_q <= in_data_i.query_time;
    end
    if (cmd_i.cap_hi) begin
      hi_key_q <= rd_key;
    end
    if (cmd_i.cap_lo) begin
      lo_key_q <= rd_key;
    end
    if (cmd_i.div_init) begin
      flag_q <= eq_time && !cmd_i.single;
      triv_q <= cmd_i.single || eq_time || (num == '0) || !same_sign || clamp;
      one_q  <= !cmd_i.single && !eq_time && (num != '0) && same_sign && clamp;
      rem_q  <= an[31:0];
      ad_q   <= ad[31:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? r2_sub[31:0] : r2[31:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], ge};
    end
    if (cmd_i.mul_go) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_go) begin
      case (cmd_i.comp)
        COMP_X:  res_x_q <= res;
        COMP_Y:  res_y_q <= res;
        COMP_Z:  res_z_q <= res;
        default: res_x_q <= res;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.out_x         <= res_x_q;
      out_q.out_y         <= res_y_q;
      out_q.out_z         <= res_z_q;
      out_q.zero_interval <= flag_q;
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

@@ rtl/core/kvi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe interpolator controller
// Sequences the key search, divide and mix, and owns the key count register
// and the output word handshake.
// ----------------------------------------------------------------------------
module kvi_ctrl
  import kvi_pkg::*;
#(
  parameter int MAX_KEYS = KVI_MAX_KEYS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_func_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [COUNT_W-1:0]          cfg_wdata_i,
  output kvi_cmd_t                         cmd_o,
  input  wire kvi_sts_t                    sts_i,
  output logic [$clog2(MAX_KEYS)-1:0]      rd_addr_o
);

  localparam int IW = $clog2(MAX_KEYS);

  kvi_state_e         state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [STEP_W-1:0]  step_q, step_d;
  kvi_comp_e          comp_q, comp_d;
  logic               single_q, single_d;
  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q, out_valid_d;

  logic          in_accept;
  logic          out_free;
  logic [31:0]   last_w;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] idx_inc;
  logic          hit;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_inc   = idx_q + 1'b1;
  assign hit       = sts_i.q_lt_t || (idx_inc == last_idx);

  // Clamp the key count to the table: zero counts as one key
  always_comb begin
    if (count_q == '0) begin
      last_w = '0;
    end else if (32'(count_q) > 32'(MAX_KEYS)) begin
      last_w = 32'(MAX_KEYS - 1);
    end else begin
      last_w = 32'(count_q) - 32'd1;
    end
  end
  assign last_idx = last_w[IW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_func_i == FUNC_QUERY)) begin
          state_d = (last_idx == '0) ? ST_RD_LO : ST_RD_HI;
        end
      end
      ST_RD_HI:  state_d = ST_CMP_HI;
      ST_CMP_HI: state_d = hit ? ST_RD_LO : ST_RD_HI;
      ST_RD_LO:  state_d = ST_CAP_LO;
      ST_CAP_LO: state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:    state_d = ST_ACC;
      ST_ACC:    state_d = (comp_q == COMP_Z) ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands and counters
  always_comb begin
    cmd_o       = '0;
    cmd_o.comp  = comp_q;
    idx_d       = idx_q;
    step_d      = step_q;
    comp_d      = comp_q;
    single_d    = single_q;
    rd_addr_o   = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_func_i == FUNC_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.cap_query = 1'b1;
            idx_d           = '0;
            single_d        = last_idx == '0;
          end
        end
      end
      ST_RD_HI: begin
        rd_addr_o = idx_inc;
      end
      ST_CMP_HI: begin
        // the word read holds entry idx+1, the candidate later key
        if (hit) begin
          cmd_o.cap_hi = 1'b1;
        end else begin
          idx_d = idx_inc;
        end
      end
      ST_RD_LO: begin
        rd_addr_o = idx_q;
      end
      ST_CAP_LO: begin
        cmd_o.cap_lo = 1'b1;
        cmd_o.cap_hi = single_q;
      end
      ST_SETUP: begin
        cmd_o.div_init = 1'b1;
        cmd_o.single   = single_q;
        step_d         = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        comp_d         = COMP_X;
      end
      ST_MUL: begin
        cmd_o.mul_go = 1'b1;
      end
      ST_ACC: begin
        cmd_o.acc_go = 1'b1;
        case (comp_q)
          COMP_X:  comp_d = COMP_Y;
          COMP_Y:  comp_d = COMP_Z;
          default: comp_d = COMP_X;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      comp_q      <= COMP_X;
      single_q    <= 1'b0;
      count_q     <= COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      comp_q      <= comp_d;
      single_q    <= single_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  // The search never reads past the last valid key
  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP_HI) |-> (idx_q < last_idx))
    else $error("key search ran past the last key");

  a_single_no_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_HI) |-> !single_q)
    else $error("search started with a single key");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  a_query_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_func_i == FUNC_QUERY)) |=> (state_q != ST_IDLE))
    else $error("query accepted but controller stayed idle");

endmodule
`default_nettype wire

@@ rtl/core/keyframe_vector_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyframe vector interpolator
// Holds a table of time-stamped 3-component keys and returns the linearly
// interpolated vector at a query time.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load word writes one key and is done in the
// cycle it is accepted. A query word searches the key table through the key
// memory's one read port, reading and then comparing each candidate key, reads
// the earlier key, runs a 16-step restoring divide for the blend factor and
// mixes the three components through one shared multiplier, each with a
// multiply step and then an accumulate step. The result sits in an output
// register, so the next word is taken while it waits. The key count register
// must be written only while the block is idle: the user is bound by this, the
// block itself does not enforce it. Keys never loaded read back as undefined
// values.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator
  import kvi_pkg::*;
#(
  parameter int MAX_KEYS = KVI_MAX_KEYS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kvi_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output kvi_out_t                out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i
);

  localparam int IW = $clog2(MAX_KEYS);

  kvi_cmd_t      cmd;
  kvi_sts_t      sts;
  logic [IW-1:0] rd_addr;

  kvi_ctrl #(
    .MAX_KEYS(MAX_KEYS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .rd_addr_o  (rd_addr)
  );

  kvi_dpath #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dpath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .rd_addr_i (rd_addr),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule
`default_nettype wire
